[rtl/mersenne_lucas_lehmer_test_core_assert.svh]
// assertion macros for the mersenne lucas-lehmer test core
// used by the port checker; no other dependencies
`ifndef MERSENNE_LUCAS_LEHMER_TEST_CORE_ASSERT_SVH
`define MERSENNE_LUCAS_LEHMER_TEST_CORE_ASSERT_SVH

// property that must hold at every edge out of reset
`define MLLT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mllt assertion failed");

// condition in one cycle implies a property in the next
`define MLLT_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mllt assertion failed");

`endif

[rtl/mllt_pkg.sv]
// shared constants, types and tables of the mersenne lucas-lehmer test core
// no dependencies
package mllt_pkg;

  localparam int unsigned WIDTH   = 64;
  localparam int unsigned InW     = 64;
  localparam int unsigned ExpW    = 7;
  localparam int unsigned HalfW   = (WIDTH + 1) / 2;
  localparam int unsigned ProdW   = 4 * HalfW;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QAddrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic StatusMersenne    = 1'b0;
  localparam logic StatusNotMersenne = 1'b1;

  localparam logic [WIDTH-1:0] SeedVal = WIDTH'(4);
  localparam logic [WIDTH-1:0] TwoVal  = WIDTH'(2);
  localparam logic [ExpW-1:0]  ExpTwo  = ExpW'(2);

  typedef struct packed {
    logic [WIDTH-1:0] value;
    logic [ExpW-1:0]  exponent;
    logic             status;
    logic             is_prime;
    logic             run_ll;
  } q_entry_t;

  // sieve over all exponent codes
  function automatic logic [(1 << ExpW)-1:0] prime_bits();
    logic [(1 << ExpW)-1:0] b;
    b    = '1;
    b[0] = 1'b0;
    b[1] = 1'b0;
    for (int i = 2; i < (1 << ExpW); i++) begin
      if (b[i]) begin
        for (int j = 2 * i; j < (1 << ExpW); j += i) begin
          b[j] = 1'b0;
        end
      end
    end
    return b;
  endfunction

  localparam logic [(1 << ExpW)-1:0] PrimeBits = prime_bits();

endpackage

[rtl/mllt_front.sv]
// front end: input register and classification of the candidate word
// depends on mllt_pkg
module mllt_front import mllt_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [InW-1:0] value_i,
  output logic           full_o,
  output logic           q_push_o,
  output q_entry_t       q_entry_o,
  input  logic           q_full_i
);

  logic             valid_q, valid_d;
  logic [WIDTH-1:0] value_q;
  logic             accept;
  logic [WIDTH:0]   nxt_full;
  logic             mers;
  logic [ExpW-1:0]  exp_enc;
  logic             prime_ok;

  assign full_o   = valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = valid_q && !q_full_i;

  always_comb begin
    valid_d = valid_q;
    if (q_push_o) valid_d = 1'b0;
    if (accept)   valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= value_i[WIDTH-1:0];
    end
  end

  // value+1 is one-hot with its bit at the exponent when the word is mersenne
  assign nxt_full = {1'b0, value_q} + (WIDTH + 1)'(1);
  assign mers     = (value_q & nxt_full[WIDTH-1:0]) == '0;

  always_comb begin
    exp_enc = '0;
    for (int i = 0; i <= WIDTH; i++) begin
      if (nxt_full[i]) exp_enc = exp_enc | ExpW'(i);
    end
  end

  assign prime_ok = PrimeBits[exp_enc];

  always_comb begin
    q_entry_o.value = value_q;
    if (!mers) begin
      q_entry_o.status   = StatusNotMersenne;
      q_entry_o.exponent = '0;
      q_entry_o.is_prime = 1'b0;
      q_entry_o.run_ll   = 1'b0;
    end else begin
      q_entry_o.status   = StatusMersenne;
      q_entry_o.exponent = exp_enc;
      q_entry_o.is_prime = (exp_enc == ExpTwo);
      q_entry_o.run_ll   = prime_ok && (exp_enc != ExpTwo);
    end
  end

endmodule

[rtl/mllt_fifo.sv]
// short request queue between the front end and the test engine
// depends on mllt_pkg
module mllt_fifo import mllt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output q_entry_t entry_o
);

  q_entry_t          mem_q [QDepth];
  logic [QAddrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QAddrW'(QDepth - 1)) ? '0 : wptr_q + QAddrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QAddrW'(QDepth - 1)) ? '0 : rptr_q + QAddrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

[rtl/mllt_back.sv]
// test engine: lucas-lehmer iterations on one shared half-width multiplier
// and the result register; depends on mllt_pkg
module mllt_back import mllt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  q_entry_t        q_entry_i,
  output logic            q_pop_o,
  output logic            res_valid_o,
  input  logic            res_pop_i,
  output logic            res_status_o,
  output logic [ExpW-1:0] res_exponent_o,
  output logic            res_is_prime_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ0  = 3'd1;
  localparam logic [2:0] S_SQ1  = 3'd2;
  localparam logic [2:0] S_SQ2  = 3'd3;
  localparam logic [2:0] S_SQ3  = 3'd4;
  localparam logic [2:0] S_FOLD = 3'd5;
  localparam logic [2:0] S_FIX  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [WIDTH-1:0]   s_q, s_d;
  logic [WIDTH-1:0]   m_q, m_d;
  logic [ExpW-1:0]    p_q, p_d;
  logic [ExpW-1:0]    cnt_q, cnt_d;
  logic [2*HalfW-1:0] mul_q;
  logic [ProdW-1:0]   acc_q, acc_d;
  logic [WIDTH:0]     t_q, t_d;

  logic               res_valid_q, res_valid_d;
  logic               res_status_q, res_status_d;
  logic [ExpW-1:0]    res_exp_q, res_exp_d;
  logic               res_prime_q, res_prime_d;

  logic               out_free, start;
  logic [2*HalfW-1:0] s_ext, mul_p;
  logic [HalfW-1:0]   a0, a1, mul_a, mul_b;
  logic [ProdW-1:0]   m_ext, fold_lo, fold_hi;
  logic [WIDTH:0]     t2;
  logic [WIDTH-1:0]   r, s_new;

  assign out_free = !res_valid_q || res_pop_i;
  assign start    = (state_q == S_IDLE) && q_valid_i && out_free;
  assign q_pop_o  = start;

  // square split into halves: lo*lo, lo*hi (counted twice), hi*hi
  assign s_ext = (2 * HalfW)'(s_q);
  assign a0    = s_ext[HalfW-1:0];
  assign a1    = s_ext[2*HalfW-1:HalfW];
  assign mul_a = (state_q == S_SQ2) ? a1 : a0;
  assign mul_b = (state_q == S_SQ0) ? a0 : a1;
  assign mul_p = (2 * HalfW)'(mul_a) * (2 * HalfW)'(mul_b);

  // mersenne fold: x is congruent to (x & m) + (x >> p) modulo 2^p-1
  assign m_ext   = ProdW'(m_q);
  assign fold_lo = acc_q & m_ext;
  assign fold_hi = acc_q >> p_q;
  assign t2      = (WIDTH + 1)'(t_q[WIDTH-1:0] & m_q) + (t_q >> p_q);
  assign r       = (t2 == (WIDTH + 1)'(m_q)) ? '0 : t2[WIDTH-1:0];
  assign s_new   = (r >= TwoVal) ? (r - TwoVal)
                 : WIDTH'((WIDTH + 1)'(r) + (WIDTH + 1)'(m_q) - (WIDTH + 1)'(TwoVal));

  always_comb begin
    state_d      = state_q;
    s_d          = s_q;
    m_d          = m_q;
    p_d          = p_q;
    cnt_d        = cnt_q;
    acc_d        = acc_q;
    t_d          = t_q;
    res_valid_d  = res_valid_q && !res_pop_i;
    res_status_d = res_status_q;
    res_exp_d    = res_exp_q;
    res_prime_d  = res_prime_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (q_entry_i.run_ll) begin
            s_d     = SeedVal;
            m_d     = q_entry_i.value;
            p_d     = q_entry_i.exponent;
            cnt_d   = q_entry_i.exponent - ExpTwo;
            state_d = S_SQ0;
          end else begin
            res_valid_d  = 1'b1;
            res_status_d = q_entry_i.status;
            res_exp_d    = q_entry_i.exponent;
            res_prime_d  = q_entry_i.is_prime;
          end
        end
      end
      S_SQ0: begin
        state_d = S_SQ1;
      end
      S_SQ1: begin
        acc_d   = ProdW'(mul_q);
        state_d = S_SQ2;
      end
      S_SQ2: begin
        acc_d   = acc_q + (ProdW'(mul_q) << (HalfW + 1));
        state_d = S_SQ3;
      end
      S_SQ3: begin
        acc_d   = acc_q + (ProdW'(mul_q) << (2 * HalfW));
        state_d = S_FOLD;
      end
      S_FOLD: begin
        t_d     = (WIDTH + 1)'(fold_lo[WIDTH-1:0]) + (WIDTH + 1)'(fold_hi[WIDTH-1:0]);
        state_d = S_FIX;
      end
      S_FIX: begin
        s_d = s_new;
        if (cnt_q == ExpW'(1)) begin
          res_valid_d  = 1'b1;
          res_status_d = StatusMersenne;
          res_exp_d    = p_q;
          res_prime_d  = (s_new == '0);
          state_d      = S_IDLE;
        end else begin
          cnt_d   = cnt_q - ExpW'(1);
          state_d = S_SQ0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q          <= s_d;
    m_q          <= m_d;
    p_q          <= p_d;
    cnt_q        <= cnt_d;
    mul_q        <= mul_p;
    acc_q        <= acc_d;
    t_q          <= t_d;
    res_status_q <= res_status_d;
    res_exp_q    <= res_exp_d;
    res_prime_q  <= res_prime_d;
  end

  assign res_valid_o    = res_valid_q;
  assign res_status_o   = res_status_q;
  assign res_exponent_o = res_exp_q;
  assign res_is_prime_o = res_prime_q;

endmodule

[rtl/mersenne_lucas_lehmer_test_core.sv]
// channel   ports                            direction  accepted when
// input     push, full, value_i              in         push && !full
// result    empty, pop, status_o,            out        pop && !empty
//           exponent_o, is_prime_o
// a word that needs no test goes from the front register through the queue straight
// to the result register; a prime exponent p >= 3 runs p-2 iterations, each through
// S_SQ0 to S_SQ3, S_FOLD and S_FIX on the shared 32x32 squaring multiplier, longest for p = 61
// the front register and a 2-entry queue keep taking words while the engine runs
// reset clears only the control state; there is no clearing pass
// top level: front end, request queue, test engine; depends on mllt_pkg
module mersenne_lucas_lehmer_test_core import mllt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [InW-1:0]  value_i,
  output logic            empty,
  input  logic            pop,
  output logic            status_o,
  output logic [ExpW-1:0] exponent_o,
  output logic            is_prime_o
);

  logic     q_push, q_full, q_empty, q_pop, res_valid;
  q_entry_t q_in, q_out;

  mllt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .value_i   (value_i),
    .full_o    (full),
    .q_push_o  (q_push),
    .q_entry_o (q_in),
    .q_full_i  (q_full)
  );

  mllt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (q_out)
  );

  mllt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (!q_empty),
    .q_entry_i      (q_out),
    .q_pop_o        (q_pop),
    .res_valid_o    (res_valid),
    .res_pop_i      (pop),
    .res_status_o   (status_o),
    .res_exponent_o (exponent_o),
    .res_is_prime_o (is_prime_o)
  );

  assign empty = !res_valid;

endmodule

[rtl/mllt_checker.sv]
// port checker for the mersenne lucas-lehmer test core, bound to the top level
// depends on mllt_pkg and the assertion macro header
`include "mersenne_lucas_lehmer_test_core_assert.svh"

module mllt_checker import mllt_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            empty_i,
  input logic            pop_i,
  input logic            status_i,
  input logic [ExpW-1:0] exponent_i,
  input logic            is_prime_i
);

  // a rejected word carries no exponent and no prime flag
  `MLLT_ASSERT(a_not_mers_clean, clk_i, rst_ni,
    empty_i || (status_i == StatusMersenne) || ((exponent_i == '0) && !is_prime_i))

  // a prime mersenne number has exponent two or an odd exponent
  `MLLT_ASSERT(a_prime_exp_odd, clk_i, rst_ni,
    empty_i || !is_prime_i || (exponent_i == ExpTwo) || exponent_i[0])

  // exponent never beyond the word width
  `MLLT_ASSERT(a_exp_range, clk_i, rst_ni,
    empty_i || (exponent_i <= ExpW'(WIDTH)))

  // a waiting result stays put until taken
  `MLLT_ASSERT_NEXT(a_result_held, clk_i, rst_ni, !empty_i && !pop_i,
    !empty_i && $stable(status_i) && $stable(exponent_i) && $stable(is_prime_i))

endmodule

bind mersenne_lucas_lehmer_test_core mllt_checker u_mllt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty_i    (empty),
  .pop_i      (pop),
  .status_i   (status_o),
  .exponent_i (exponent_o),
  .is_prime_i (is_prime_o)
);

[sim/mersenne_verdict_checker.sv]
`timescale 1ns / 100ps
// checker for the mersenne lucas-lehmer test core: watches both queue ports,
// predicts each verdict and compares it; depends on mllt_pkg
module mersenne_verdict_checker import mllt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  input  logic            full,
  input  logic [InW-1:0]  value_i,
  input  logic            empty,
  input  logic            pop,
  input  logic            status_o,
  input  logic [ExpW-1:0] exponent_o,
  input  logic            is_prime_o,
  output int              fails_o,
  output int              outstanding_o,
  output int              checked_o,
  output int              primes_o
);

  typedef struct packed {
    logic            status;
    logic [ExpW-1:0] exponent;
    logic            is_prime;
  } verdict_t;

  localparam logic [WIDTH-1:0] LlSeed = WIDTH'(4);
  localparam logic [WIDTH-1:0] LlTwo  = WIDTH'(2);

  verdict_t expected_verdicts[$];

  function automatic verdict_t predict_verdict(logic [InW-1:0] raw);
    logic [WIDTH-1:0]   cand;
    logic [WIDTH-1:0]   succ;
    logic [WIDTH-1:0]   s;
    logic [2*WIDTH-1:0] sq;
    int unsigned        p;
    logic               prime;
    verdict_t           v;
    // bits above the word size are dropped
    cand = raw[WIDTH-1:0];
    succ = cand + 1'b1;
    v    = '0;
    if ((cand & succ) != '0) begin
      v.status = StatusNotMersenne;
      return v;
    end
    p          = $countones(cand);
    v.status   = StatusMersenne;
    v.exponent = ExpW'(p);
    if (p == 2) begin
      prime = 1'b1;
    end else if (p < 2 || (p % 2) == 0) begin
      prime = 1'b0;
    end else begin
      prime = 1'b1;
      for (int d = 3; d * d <= p; d += 2) begin
        if (p % d == 0) prime = 1'b0;
      end
      if (prime) begin
        // lucas-lehmer residue sequence modulo the candidate
        s = LlSeed % cand;
        for (int i = 0; i + 2 < p; i++) begin
          sq = {{WIDTH{1'b0}}, s} * {{WIDTH{1'b0}}, s};
          sq = sq % {{WIDTH{1'b0}}, cand};
          s  = sq[WIDTH-1:0];
          s  = (s >= LlTwo) ? s - LlTwo : s + cand - LlTwo;
        end
        prime = (s == '0);
      end
    end
    v.is_prime = prime;
    return v;
  endfunction

  initial begin
    fails_o       = 0;
    outstanding_o = 0;
    checked_o     = 0;
    primes_o      = 0;
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      if (push && !full) begin
        expected_verdicts.push_back(predict_verdict(value_i));
      end
      if (pop && !empty) begin
        if (expected_verdicts.size() == 0) begin
          $error("verdict popped with no request outstanding");
          fails_o++;
        end else begin
          want = expected_verdicts.pop_front();
          checked_o++;
          if (want.is_prime) primes_o++;
          if (status_o !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status_o);
            fails_o++;
          end
          if (exponent_o !== want.exponent) begin
            $error("exponent mismatch: expected %0d, got %0d", want.exponent, exponent_o);
            fails_o++;
          end
          if (is_prime_o !== want.is_prime) begin
            $error("is_prime mismatch: expected %0d, got %0d", want.is_prime, is_prime_o);
            fails_o++;
          end
        end
      end
      outstanding_o = expected_verdicts.size();
    end
  end

endmodule

[sim/tb_mersenne_lucas_lehmer_test_core.sv]
`timescale 1ns / 100ps
// testbench top for the mersenne lucas-lehmer test core: directed and random
// words under several idle mixes; depends on mllt_pkg and mersenne_verdict_checker
module tb_mersenne_lucas_lehmer_test_core import mllt_pkg::*; ();

  localparam int CycleLimit   = 1000000;
  localparam int DrainCycles  = 400;
  localparam int HoldCycles   = 300;
  localparam int RandomWords  = 752;
  localparam int PhaseCount   = 4;

  logic            clk_i   = 1'b0;
  logic            rst_ni  = 1'b0;
  logic            push    = 1'b0;
  logic [InW-1:0]  value_i = '0;
  logic            pop     = 1'b0;
  logic            full;
  logic            empty;
  logic            status_o;
  logic [ExpW-1:0] exponent_o;
  logic            is_prime_o;

  int fails;
  int outstanding;
  int checked;
  int primes;
  int cycles      = 0;
  int words_sent  = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  bit hold_go     = 1'b0;
  bit hold_taken  = 1'b0;
  int hold_left   = 0;

  mersenne_lucas_lehmer_test_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .value_i    (value_i),
    .empty      (empty),
    .pop        (pop),
    .status_o   (status_o),
    .exponent_o (exponent_o),
    .is_prime_o (is_prime_o)
  );

  mersenne_verdict_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .value_i       (value_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .exponent_o    (exponent_o),
    .is_prime_o    (is_prime_o),
    .fails_o       (fails),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .primes_o      (primes)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("mersenne_lucas_lehmer_test_core verification failed");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [InW-1:0] mersenne_word(int p);
    logic [WIDTH-1:0] m;
    logic [InW-1:0]   low_mask;
    logic [InW-1:0]   noise;
    m = '0;
    for (int i = 0; i < p; i++) m[i] = 1'b1;
    low_mask = InW'({WIDTH{1'b1}});
    noise    = InW'({$urandom, $urandom});
    return (noise & ~low_mask) | InW'(m);
  endfunction

  task automatic send_word(input logic [InW-1:0] w);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push    <= 1'b1;
    value_i <= w;
    do @(posedge clk_i); while (full);
    words_sent++;
  endtask

  initial begin
    int               pick;
    int               p;
    logic [InW-1:0]   w;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: edge exponents, special words and non-mersenne patterns
    send_word('0);
    send_word(mersenne_word(1));
    send_word(mersenne_word(2));
    send_word(mersenne_word(3));
    send_word(mersenne_word(4));
    send_word(mersenne_word(5));
    send_word(mersenne_word(9));
    send_word(mersenne_word(11));
    send_word(mersenne_word(13));
    send_word(mersenne_word(23));
    send_word(mersenne_word(31));
    send_word(mersenne_word(32));
    send_word(mersenne_word(59));
    send_word(mersenne_word(61));
    send_word(mersenne_word(63));
    send_word(mersenne_word(WIDTH));
    send_word(InW'(2));
    send_word(InW'(1) << (WIDTH - 1));
    send_word(mersenne_word(WIDTH) ^ InW'(1));
    send_word(mersenne_word(WIDTH - 1) ^ InW'(1));
    send_word({(InW / 2){2'b01}});
    send_word({(InW / 2){2'b10}});

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      for (int n = 0; n < RandomWords / PhaseCount; n++) begin
        if (ph == 0 && n == 20) hold_go = 1'b1;
        pick = $urandom_range(99);
        if (pick < 55) begin
          w = mersenne_word($urandom_range(WIDTH));
        end else if (pick < 75) begin
          p = $urandom_range(WIDTH);
          w = mersenne_word(p) ^ (InW'(1) << $urandom_range(WIDTH - 1));
        end else begin
          w = {$urandom, $urandom};
        end
        send_word(w);
      end
    end

    @(negedge clk_i);
    push      <= 1'b0;
    stall_pct  = 0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d words sent, %0d verdicts checked, %0d of them prime", words_sent, checked,
             primes);
    $display("idle mixes: none, sender 59%%, receiver 59%%, both 6%%, plus one long pop hold-off");
    if (fails == 0 && outstanding == 0) begin
      $display("mersenne_lucas_lehmer_test_core verification clean");
    end else begin
      $display("mersenne_lucas_lehmer_test_core verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/mllt_pkg.sv
rtl/mllt_front.sv
rtl/mllt_fifo.sv
rtl/mllt_back.sv
rtl/mersenne_lucas_lehmer_test_core.sv
rtl/mllt_checker.sv
sim/mersenne_verdict_checker.sv
sim/tb_mersenne_lucas_lehmer_test_core.sv
